// ----- src/rpf_pkg.sv -----
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants of the radio packet framer
// Request and result codes, framer modes, result bundle, preamble table, ring and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package rpf_pkg;

    // request codes on the event channel
    typedef enum logic [2:0] {
        REQ_LOAD     = 3'd0,
        REQ_TX       = 3'd1,
        REQ_IDLE     = 3'd2,
        REQ_ENC      = 3'd3,
        REQ_SEND     = 3'd4,
        REQ_DEC      = 3'd5,
        REQ_START    = 3'd6,
        REQ_STRENGTH = 3'd7
    } req_t;

    // result kinds on the result channel
    typedef enum logic [2:0] {
        KIND_STATUS  = 3'd0,
        KIND_FIFO    = 3'd1,
        KIND_ENCODE  = 3'd2,
        KIND_FLUSH   = 3'd3,
        KIND_DECODE  = 3'd4,
        KIND_RX      = 3'd5,
        KIND_DONE    = 3'd6,
        KIND_CAPTURE = 3'd7
    } kind_t;

    // framer modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_RX      = 3'd1,
        MODE_TX_PRE  = 3'd2,
        MODE_TX_BODY = 3'd3,
        MODE_TX_END  = 3'd4
    } mode_t;

    // encoded byte ring
    localparam int RING_DEPTH   = 4;
    localparam int RING_PTR_W   = 2;
    localparam int RING_CNT_W   = 3;
    localparam int REFILL_LEVEL = 2;

    // result queue
    localparam int MAX_RES   = 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    typedef struct packed {
        kind_t       out_kind;
        logic [7:0]  out_byte;
        logic [7:0]  out_index;
        logic        accepted;
        logic [9:0]  strength;
        logic        last;
    } result_t;

    // results of one event pushed into the queue
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res1;
        result_t    res0;
    } q_push_t;

    // start preamble, padded with 0x0f
    function automatic logic [7:0] pre_byte(input logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'hf0;
            4'd1:    b = 8'hf0;
            4'd2:    b = 8'hf0;
            4'd3:    b = 8'hff;
            4'd4:    b = 8'h00;
            4'd5:    b = 8'hff;
            4'd6:    b = 8'h0f;
            4'd7:    b = 8'h00;
            4'd8:    b = 8'hff;
            default: b = 8'h0f;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- src/rpf_in_if.sv -----
// ----------------------------------------------------------------------------
// rpf_in_if: event channel
// Valid/ready channel carrying one framer event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpf_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic [9:0] sample;

    modport source (output valid, req_type, byte_index, data_byte, sample, input ready);
    modport sink   (input valid, req_type, byte_index, data_byte, sample, output ready);
endinterface

`default_nettype wire

// ----- src/rpf_out_if.sv -----
// ----------------------------------------------------------------------------
// rpf_out_if: result channel
// Valid/ready channel carrying one framer result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] out_index;
    logic       accepted;
    logic [9:0] strength;
    logic       last;

    modport source (output valid, out_kind, out_byte, out_index, accepted, strength, last,
                    input ready);
    modport sink   (input valid, out_kind, out_byte, out_index, accepted, strength, last,
                    output ready);
endinterface

`default_nettype wire

// ----- src/rpf_core.sv -----
// ----------------------------------------------------------------------------
// rpf_core: framer state and event decode
// Updates mode, ring and positions on each accepted beat, reads the message
// buffer and registers up to two results for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_core #(
    parameter int MSG_LEN      = 36,
    parameter int PREAMBLE_LEN = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rpf_in_if.sink                     evt,
    input  logic [rpf_pkg::Q_CNT_W-1:0] q_level,
    output rpf_pkg::q_push_t           push
);
    import rpf_pkg::*;

    localparam int AW = $clog2(MSG_LEN);

    // state
    mode_t                 mode_reg, mode_next;
    logic                  pend_reg, pend_next;
    logic [7:0]            tx_pos_reg, tx_pos_next;
    logic [7:0]            rx_pos_reg, rx_pos_next;
    logic [7:0]            ring_reg [RING_DEPTH];
    logic [RING_PTR_W-1:0] head_reg, head_next;
    logic [RING_PTR_W-1:0] tail_reg, tail_next;
    logic [RING_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic [9:0]            str_reg, str_next;

    // message buffer
    logic [7:0]            msg_mem [MSG_LEN];
    logic [7:0]            rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         rd_addr;
    logic                  ring_we;

    // result stage
    result_t               stg_res_reg [MAX_RES];
    result_t               stg_res_next [MAX_RES];
    logic [MAX_RES-1:0]    stg_mem_reg, stg_mem_next;
    logic [1:0]            stg_cnt_reg, stg_cnt_next;

    // shared decode terms
    logic                  accept;
    logic                  tx_busy;
    logic                  start_ok;
    logic                  have_byte;
    logic [RING_CNT_W-1:0] rcnt_after;
    logic [7:0]            pre_inc;
    logic [7:0]            rx_inc;
    logic                  rx_final;
    req_t                  req;

    assign req       = req_t'(evt.req_type);
    assign accept    = evt.valid && evt.ready;
    assign tx_busy   = (mode_reg == MODE_TX_PRE) || (mode_reg == MODE_TX_BODY) ||
                       (mode_reg == MODE_TX_END);
    assign start_ok  = pend_reg && !tx_busy;
    assign have_byte = (rcnt_reg != '0);
    assign rcnt_after = rcnt_reg - RING_CNT_W'(have_byte);
    assign pre_inc   = tx_pos_reg + 8'd1;
    assign rx_inc    = rx_pos_reg + 8'd1;
    assign rx_final  = (rx_inc >= 8'(MSG_LEN));

    // room for a full result pair behind what is queued or staged
    assign evt.ready = ({1'b0, q_level} + (Q_CNT_W + 1)'(stg_cnt_reg))
                       <= (Q_CNT_W + 1)'(Q_DEPTH - MAX_RES);

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        tx_pos_next = tx_pos_reg;
        rx_pos_next = rx_pos_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        rcnt_next   = rcnt_reg;
        str_next    = str_reg;
        mem_we      = 1'b0;
        ring_we     = 1'b0;
        if (accept)
        begin
            case (req)
                REQ_LOAD:
                begin
                    mem_we = !pend_reg && !tx_busy && (evt.byte_index < 8'(MSG_LEN));
                end
                REQ_TX:
                begin
                    pend_next = 1'b1;
                end
                REQ_IDLE:
                begin
                    if (start_ok)
                    begin
                        head_next   = '0;
                        tail_next   = '0;
                        rcnt_next   = '0;
                        tx_pos_next = 8'd1;
                        mode_next   = (PREAMBLE_LEN <= 1) ? MODE_TX_BODY : MODE_TX_PRE;
                    end
                end
                REQ_ENC:
                begin
                    if (rcnt_reg < RING_CNT_W'(RING_DEPTH))
                    begin
                        ring_we   = 1'b1;
                        tail_next = tail_reg + 1'b1;
                        rcnt_next = rcnt_reg + 1'b1;
                    end
                end
                REQ_SEND:
                begin
                    case (mode_reg)
                        MODE_TX_PRE:
                        begin
                            if (pre_inc >= 8'(PREAMBLE_LEN))
                            begin
                                mode_next   = MODE_TX_BODY;
                                tx_pos_next = 8'd1;
                            end
                            else
                            begin
                                tx_pos_next = pre_inc;
                            end
                        end
                        MODE_TX_BODY:
                        begin
                            rcnt_next = rcnt_after;
                            if (have_byte)
                                head_next = head_reg + 1'b1;
                            if (rcnt_after >= RING_CNT_W'(REFILL_LEVEL))
                                tx_pos_next = tx_pos_reg;
                            else if (tx_pos_reg < 8'(MSG_LEN))
                                tx_pos_next = pre_inc;
                            else if (rcnt_after == '0)
                                mode_next = MODE_TX_END;
                        end
                        MODE_TX_END:
                        begin
                            mode_next = MODE_IDLE;
                            pend_next = 1'b0;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                REQ_DEC:
                begin
                    if (mode_reg == MODE_RX)
                    begin
                        rx_pos_next = rx_inc;
                        if (rx_final)
                            mode_next = MODE_IDLE;
                    end
                end
                REQ_START:
                begin
                    if (!tx_busy)
                    begin
                        rx_pos_next = '0;
                        mode_next   = MODE_RX;
                        str_next    = '0;
                    end
                end
                REQ_STRENGTH:
                begin
                    str_next = evt.sample;
                end
                default:
                begin
                    str_next = str_reg;
                end
            endcase
        end
    end

    // results of this beat
    always_comb
    begin
        result_t ext;
        logic    ext_vld;
        logic    ext_mem;
        stg_res_next[0] = '0;
        stg_res_next[1] = '0;
        stg_mem_next    = '0;
        stg_cnt_next    = 2'd0;
        ext             = '0;
        ext_vld         = 1'b0;
        ext_mem         = 1'b0;
        if (accept)
        begin
            case (req)
                REQ_TX:
                begin
                    stg_res_next[0].out_kind = KIND_STATUS;
                    stg_res_next[0].accepted = !pend_reg;
                    stg_res_next[0].last     = 1'b1;
                    stg_cnt_next             = 2'd1;
                end
                REQ_IDLE:
                begin
                    if (start_ok)
                    begin
                        stg_res_next[0].out_kind = KIND_ENCODE;
                        stg_mem_next[0]          = 1'b1;
                        stg_res_next[1].out_kind = KIND_FIFO;
                        stg_res_next[1].out_byte = pre_byte(4'd0);
                        stg_res_next[1].last     = 1'b1;
                        stg_cnt_next             = 2'd2;
                    end
                end
                REQ_SEND:
                begin
                    case (mode_reg)
                        MODE_TX_PRE:
                        begin
                            stg_res_next[0].out_kind = KIND_FIFO;
                            stg_res_next[0].out_byte = pre_byte(tx_pos_reg[3:0]);
                            stg_res_next[0].last     = 1'b1;
                            stg_cnt_next             = 2'd1;
                        end
                        MODE_TX_BODY:
                        begin
                            // refill request or flush behind the dequeued byte
                            if (rcnt_after >= RING_CNT_W'(REFILL_LEVEL))
                            begin
                                ext_vld = 1'b0;
                            end
                            else if (tx_pos_reg < 8'(MSG_LEN))
                            begin
                                ext.out_kind = KIND_ENCODE;
                                ext.last     = 1'b1;
                                ext_mem      = 1'b1;
                                ext_vld      = 1'b1;
                            end
                            else if (rcnt_after != '0)
                            begin
                                ext.out_kind = KIND_FLUSH;
                                ext.last     = 1'b1;
                                ext_vld      = 1'b1;
                            end
                            if (have_byte)
                            begin
                                stg_res_next[0].out_kind = KIND_FIFO;
                                stg_res_next[0].out_byte = ring_reg[head_reg];
                                stg_res_next[0].last     = !ext_vld;
                                stg_res_next[1]          = ext;
                                stg_mem_next[1]          = ext_mem;
                                stg_cnt_next             = ext_vld ? 2'd2 : 2'd1;
                            end
                            else
                            begin
                                stg_res_next[0] = ext;
                                stg_mem_next[0] = ext_mem;
                                stg_cnt_next    = {1'b0, ext_vld};
                            end
                        end
                        MODE_TX_END:
                        begin
                            stg_res_next[0].out_kind = KIND_DONE;
                            stg_res_next[0].last     = 1'b1;
                            stg_cnt_next             = 2'd1;
                        end
                        MODE_RX:
                        begin
                            stg_res_next[0].out_kind = KIND_DECODE;
                            stg_res_next[0].out_byte = evt.data_byte;
                            stg_res_next[0].last     = 1'b1;
                            stg_cnt_next             = 2'd1;
                        end
                        default:
                        begin
                            stg_cnt_next = 2'd0;
                        end
                    endcase
                end
                REQ_DEC:
                begin
                    if (mode_reg == MODE_RX)
                    begin
                        stg_res_next[0].out_kind  = KIND_RX;
                        stg_res_next[0].out_byte  = evt.data_byte;
                        stg_res_next[0].out_index = rx_pos_reg;
                        stg_res_next[0].strength  = rx_final ? str_reg : 10'd0;
                        stg_res_next[0].last      = rx_final;
                        stg_cnt_next              = 2'd1;
                    end
                end
                REQ_START:
                begin
                    if (!tx_busy)
                    begin
                        stg_res_next[0].out_kind = KIND_CAPTURE;
                        stg_res_next[0].last     = 1'b1;
                        stg_cnt_next             = 2'd1;
                    end
                end
                default:
                begin
                    stg_cnt_next = 2'd0;
                end
            endcase
        end
    end

    // message read address: byte 0 on an idle request or past the message end, else the next body byte
    always_comb
    begin
        if (req == REQ_IDLE || tx_pos_reg >= 8'(MSG_LEN))
            rd_addr = '0;
        else
            rd_addr = tx_pos_reg[AW-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            pend_reg    <= 1'b0;
            tx_pos_reg  <= '0;
            rx_pos_reg  <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            rcnt_reg    <= '0;
            str_reg     <= '0;
            stg_cnt_reg <= 2'd0;
        end
        else
        begin
            mode_reg    <= mode_next;
            pend_reg    <= pend_next;
            tx_pos_reg  <= tx_pos_next;
            rx_pos_reg  <= rx_pos_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            rcnt_reg    <= rcnt_next;
            str_reg     <= str_next;
            stg_cnt_reg <= stg_cnt_next;
        end
    end

    // payload registers: ring, result stage
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_reg[tail_reg] <= evt.data_byte;
        stg_res_reg[0] <= stg_res_next[0];
        stg_res_reg[1] <= stg_res_next[1];
        stg_mem_reg    <= stg_mem_next;
    end

    // message buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            msg_mem[evt.byte_index[AW-1:0]] <= evt.data_byte;
        rdata_reg <= msg_mem[rd_addr];
    end

    // staged results to the queue, message byte merged in
    always_comb
    begin
        push.cnt  = stg_cnt_reg;
        push.res0 = stg_res_reg[0];
        push.res1 = stg_res_reg[1];
        if (stg_mem_reg[0])
            push.res0.out_byte = rdata_reg;
        if (stg_mem_reg[1])
            push.res1.out_byte = rdata_reg;
    end

endmodule

`default_nettype wire

// ----- src/rpf_outq.sv -----
// ----------------------------------------------------------------------------
// rpf_outq: result queue
// Four-entry queue taking up to two results a cycle and giving one beat a
// cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_outq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpf_pkg::q_push_t             push,
    output logic [rpf_pkg::Q_CNT_W-1:0]  q_level,
    rpf_out_if.source                    res
);
    import rpf_pkg::*;

    result_t              q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg, wr_next;
    logic [Q_PTR_W-1:0]   rd_reg, rd_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 pop;
    result_t              head;

    assign head    = q_reg[rd_reg];
    assign pop     = res.valid && res.ready;
    assign q_level = cnt_reg;

    // head entry drives the channel
    assign res.valid     = (cnt_reg != '0);
    assign res.out_kind  = head.out_kind;
    assign res.out_byte  = head.out_byte;
    assign res.out_index = head.out_index;
    assign res.accepted  = head.accepted;
    assign res.strength  = head.strength;
    assign res.last      = head.last;

    // pointer and level update
    always_comb
    begin
        wr_next  = wr_reg + Q_PTR_W'(push.cnt);
        rd_next  = rd_reg + Q_PTR_W'(pop);
        cnt_next = cnt_reg + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry writes
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            q_reg[wr_reg] <= push.res0;
        if (push.cnt == 2'd2)
            q_reg[wr_reg + 1'b1] <= push.res1;
    end

endmodule

`default_nettype wire

// ----- src/radio_packet_framer.sv -----
// ----------------------------------------------------------------------------
// radio_packet_framer: packet framer for a byte radio
// Transmit preamble and body sequencing, receive capture and strength report.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one event beat (req_type, byte_index, data_byte, sample) and
//   res carries result beats; both are valid/ready, a beat moves when both
//   are high. An event yields zero, one or two result beats, in order.
//   An event's decision and the message buffer read are registered in the
//   result stage, the result queue then takes them and its head entry drives
//   res; a second result follows the first.
//   Throughput: one event per cycle while results drain at one per cycle.
//   Events producing two results are limited by the single result port, so
//   a run of them is held back by evt.ready while the queue drains.
//   evt.ready drops when the four-entry result queue plus the staged results
//   leave no room for a full pair, so a stalled receiver back-pressures the
//   event side and nothing is lost.
//   Reset (rst_n low, asynchronous) returns the framer to idle with no send
//   pending, empties the ring and the queue; the message buffer holds
//   whatever was loaded and must be reloaded before a send.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_packet_framer #(
    parameter int MSG_LEN      = 36,
    parameter int PREAMBLE_LEN = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    rpf_in_if.sink    evt,
    rpf_out_if.source res
);
    import rpf_pkg::*;

    q_push_t            push;
    logic [Q_CNT_W-1:0] q_level;

    // event decode and state
    rpf_core #(
        .MSG_LEN      (MSG_LEN),
        .PREAMBLE_LEN (PREAMBLE_LEN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .q_level (q_level),
        .push    (push)
    );

    // result queue
    rpf_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_level (q_level),
        .res     (res)
    );

    // queue never overflows: queued plus staged stays within depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, q_level} + (Q_CNT_W + 1)'(push.cnt)) <= (Q_CNT_W + 1)'(Q_DEPTH))
        else $error("result queue overflow");

    // a result pair ends on its second beat only
    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (push.res1.last && !push.res0.last))
        else $error("result pair last flag wrong");

    // a transmit request always answers with a single status
    a_tx_status: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready && (evt.req_type == REQ_TX)) |=>
        ((push.cnt == 2'd1) && (push.res0.out_kind == KIND_STATUS)))
        else $error("transmit request without status");

    // no staged result pair while the queue is too full to take it
    a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (q_level <= Q_CNT_W'(Q_DEPTH - MAX_RES)))
        else $error("result pair staged without room");

endmodule

`default_nettype wire
